// ===== src/pba_pkg.sv =====
// Shared types, constants and helper functions for the page bitmap allocator.
package pba_pkg;

  localparam int CHUNK_COUNT     = 7;
  localparam int PAGES_PER_CHUNK = 16;
  localparam int MAX_RUN_ORDER   = 4;

  localparam int OP_W      = 1;
  localparam int ORDER_W   = 3;
  localparam int CHUNK_W   = 3;
  localparam int PAGE_W    = 4;
  localparam int STATUS_W  = 2;
  localparam int AVAIL_W   = 7;

  localparam int MAP_W       = PAGES_PER_CHUNK;
  localparam int LEN_W       = 8;
  localparam int TOTAL_PAGES = CHUNK_COUNT * PAGES_PER_CHUNK;
  localparam int COUNT_W     = $clog2(TOTAL_PAGES + 1);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_RUN      = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_RANGE       = 2'd3
  } status_t;

  typedef struct packed {
    op_t                opcode;
    logic [ORDER_W-1:0] run_order;
    logic [CHUNK_W-1:0] chunk_index;
    logic [PAGE_W-1:0]  page_index;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [CHUNK_W-1:0] granted_chunk;
    logic [PAGE_W-1:0]  granted_page;
    logic [AVAIL_W-1:0] pages_available;
  } rsp_t;

  // Request token that walks the cell row, one cell per cycle.
  typedef struct packed {
    logic               vld;
    op_t                op;
    logic [ORDER_W-1:0] order;
    logic [CHUNK_W-1:0] chunk;
    logic [PAGE_W-1:0]  page;
    status_t            status;
    logic               found;
    logic [CHUNK_W-1:0] g_chunk;
    logic [PAGE_W-1:0]  g_page;
  } tok_t;

  function automatic logic [LEN_W-1:0] run_len(input logic [ORDER_W-1:0] order);
    return LEN_W'(1) << order;
  endfunction

  function automatic logic [MAP_W-1:0] run_mask(input logic [ORDER_W-1:0] order);
    logic [MAP_W-1:0] m;
    for (int i = 0; i < MAP_W; i++) begin
      m[i] = (LEN_W'(i) < run_len(order));
    end
    return m;
  endfunction

endpackage

// ===== src/page_bitmap_allocator.sv =====
// Top level of the page bitmap allocator: entry checks, cell row, result path.
//
// Usage: a request beat on req (req_valid/req_stall) asks to allocate or free
// a run of 2^run_order contiguous pages. Each request yields exactly one
// response beat on rsp (rsp_valid/rsp_stall) with status, granted chunk and
// page, and the free-page count after the request.
// Inside, a row of CHUNK_COUNT cells each holds one chunk's free bitmap. The
// request travels as a token one cell per cycle; on allocate the first cell
// with a fully free window claims it, on free the addressed cell checks for a
// double free and sets the run free again. Range checks happen at entry.
// A request passes through the cell registers, the pending stage and the output
// register before its response is valid. Only one request is in flight; the
// next is taken once the result has left the pending stage.
// Reset (rst, synchronous) marks every page free and sets the count to the
// total page count. When the receiver stalls, the response holds in the output
// register and one more finished result can wait in the pending stage; req_stall
// stays high until that stage drains.
module page_bitmap_allocator import pba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  tok_t tok [0:CHUNK_COUNT];
  tok_t tok_head;

  logic [CHUNK_COUNT:1] tok_vld;
  logic                 busy;
  logic                 accept;
  logic [LEN_W-1:0]     req_len;
  logic                 order_bad;
  logic                 span_bad;

  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic [LEN_W-1:0]     fin_len;
  status_t              fin_status;

  rsp_t                 pend;
  rsp_t                 pend_next;
  logic                 pend_valid;
  logic                 pend_move;

  // Entry: range checks and token build.
  always_comb begin
    req_len   = run_len(req.run_order);
    order_bad = (req.run_order > ORDER_W'(MAX_RUN_ORDER)) ||
                (req_len > LEN_W'(PAGES_PER_CHUNK));
    span_bad  = ({1'b0, req.chunk_index} >= (CHUNK_W + 1)'(CHUNK_COUNT)) ||
                ((LEN_W + 1)'(req.page_index) + (LEN_W + 1)'(req_len) >
                 (LEN_W + 1)'(PAGES_PER_CHUNK));
    tok_head.vld     = accept;
    tok_head.op      = req.opcode;
    tok_head.order   = req.run_order;
    tok_head.chunk   = req.chunk_index;
    tok_head.page    = req.page_index;
    tok_head.status  = (order_bad || (req.opcode == OP_FREE && span_bad)) ? ST_RANGE : ST_OK;
    tok_head.found   = 1'b0;
    tok_head.g_chunk = '0;
    tok_head.g_page  = '0;
  end

  assign tok[0] = tok_head;

  for (genvar i = 0; i < CHUNK_COUNT; i++) begin : g_cell
    pba_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (CHUNK_W'(i)),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    for (int i = 1; i <= CHUNK_COUNT; i++) begin
      tok_vld[i] = tok[i].vld;
    end
  end

  // Hold off new requests while a token walks the row or a result waits.
  assign busy      = (|tok_vld[CHUNK_COUNT:1]) || pend_valid;
  assign req_stall = busy;
  assign accept    = req_valid && !busy;

  // Exit: settle status, move the count, build the response.
  always_comb begin
    fin_len    = run_len(tok[CHUNK_COUNT].order);
    fin_status = tok[CHUNK_COUNT].status;
    if (tok[CHUNK_COUNT].op == OP_ALLOC && fin_status == ST_OK && !tok[CHUNK_COUNT].found) begin
      fin_status = ST_NO_RUN;
    end
    count_next = count;
    if (tok[CHUNK_COUNT].vld && fin_status == ST_OK) begin
      if (tok[CHUNK_COUNT].op == OP_ALLOC) begin
        count_next = count - COUNT_W'(fin_len);
      end else begin
        count_next = count + COUNT_W'(fin_len);
      end
    end
    pend_next.status          = fin_status;
    pend_next.granted_chunk   = (fin_status == ST_OK) ? tok[CHUNK_COUNT].g_chunk : '0;
    pend_next.granted_page    = (fin_status == ST_OK) ? tok[CHUNK_COUNT].g_page : '0;
    pend_next.pages_available = AVAIL_W'(count_next);
  end

  assign pend_move = pend_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= COUNT_W'(TOTAL_PAGES);
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      count <= count_next;
      if (tok[CHUNK_COUNT].vld) begin
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (tok[CHUNK_COUNT].vld) begin
      pend <= pend_next;
    end
    if (pend_move) begin
      rsp <= pend;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(TOTAL_PAGES))
    else $error("free page count above total");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({tok_vld[CHUNK_COUNT:1], pend_valid}))
    else $error("more than one request in flight");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request not tracked");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.granted_chunk == '0 && rsp.granted_page == '0)
    else $error("failed request carries a grant");

  a_grant_chunk: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> ({1'b0, pend.granted_chunk} < (CHUNK_W + 1)'(CHUNK_COUNT)))
    else $error("granted chunk out of range");
`endif

endmodule

// ===== src/pba_cell.sv =====
// One chunk cell: holds the chunk's free bitmap and serves the passing token.
module pba_cell import pba_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [CHUNK_W-1:0] cell_id,
  input  tok_t               tok_in,
  output tok_t               tok_out
);

  logic [MAP_W-1:0] map;
  logic [MAP_W-1:0] map_next;
  tok_t             tok_next;

  logic [MAP_W-1:0] run;
  logic [LEN_W-1:0] len;
  logic [MAP_W-1:0] win_ok;
  logic [MAP_W-1:0] free_win;
  logic [MAP_W-1:0] alloc_win;
  logic [PAGE_W-1:0] sel_off;
  logic             any_ok;
  logic             live;

  always_comb begin
    run  = run_mask(tok_in.order);
    len  = run_len(tok_in.order);
    live = tok_in.vld && (tok_in.status == ST_OK);
    for (int off = 0; off < MAP_W; off++) begin
      win_ok[off] = ((LEN_W + 1)'(off) + (LEN_W + 1)'(len) <= (LEN_W + 1)'(MAP_W)) &&
                    ((map & (run << off)) == (run << off));
    end
    // Lowest fitting window wins.
    sel_off = '0;
    for (int off = MAP_W - 1; off >= 0; off--) begin
      if (win_ok[off]) begin
        sel_off = PAGE_W'(off);
      end
    end
    any_ok    = |win_ok;
    alloc_win = run << sel_off;
    free_win  = run << tok_in.page;

    tok_next = tok_in;
    map_next = map;
    if (live && tok_in.op == OP_ALLOC && !tok_in.found && any_ok) begin
      map_next         = map & ~alloc_win;
      tok_next.found   = 1'b1;
      tok_next.g_chunk = cell_id;
      tok_next.g_page  = sel_off;
    end else if (live && tok_in.op == OP_FREE && tok_in.chunk == cell_id) begin
      if ((map & free_win) != '0) begin
        tok_next.status = ST_DOUBLE_FREE;
      end else begin
        map_next = map | free_win;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map         <= '1;
      tok_out.vld <= 1'b0;
    end else begin
      map         <= map_next;
      tok_out.vld <= tok_next.vld;
    end
    tok_out.op      <= tok_next.op;
    tok_out.order   <= tok_next.order;
    tok_out.chunk   <= tok_next.chunk;
    tok_out.page    <= tok_next.page;
    tok_out.status  <= tok_next.status;
    tok_out.found   <= tok_next.found;
    tok_out.g_chunk <= tok_next.g_chunk;
    tok_out.g_page  <= tok_next.g_page;
  end

endmodule

// ===== sim/tb_page_bitmap_allocator.sv =====
// Self-checking testbench for the page bitmap allocator: directed and random request beats.
module tb_page_bitmap_allocator;
  import pba_pkg::*;

  localparam int RANDOM_ITEMS   = 1925;
  localparam int DRAIN_CYCLES   = 2 * (CHUNK_COUNT + 2);
  localparam int TIMEOUT_CYCLES = 500_000;

  // A run handed out by an allocate beat, kept so that later beats can free it.
  typedef struct packed {
    logic [CHUNK_W-1:0] chunk;
    logic [PAGE_W-1:0]  page;
    logic [ORDER_W-1:0] order;
  } run_t;

  // Receiver behavior: open, light, half or heavy backpressure.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HALF,
    RX_HEAVY
  } rx_mode_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Mirror of the allocator: one free bitmap per chunk (set bit = free page)
  // and the running free-page count.
  logic [PAGES_PER_CHUNK-1:0] free_map [CHUNK_COUNT];
  logic [COUNT_W-1:0]         mirror_count;

  rsp_t expected_rsps[$];  // predicted response beats, oldest first
  run_t live_runs[$];      // runs granted and not yet picked for freeing

  int       mismatches = 0;
  int       burst_left = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_left    = 0;

  page_bitmap_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [PAGES_PER_CHUNK-1:0] span_mask(input int len, input int first);
    logic [PAGES_PER_CHUNK-1:0] m;
    m = '0;
    for (int i = first; i < first + len; i++) m[i] = 1'b1;
    return m;
  endfunction

  function automatic void reset_mirror();
    for (int c = 0; c < CHUNK_COUNT; c++) free_map[c] = '1;
    mirror_count = COUNT_W'(TOTAL_PAGES);
    live_runs.delete();
  endfunction

  // Apply one accepted request to the mirror and return the response it must produce.
  function automatic rsp_t apply_request(input req_t r);
    rsp_t                       res;
    logic [PAGES_PER_CHUNK-1:0] win;
    int                         len;
    bit                         found;
    res        = '0;
    res.status = ST_OK;
    found      = 1'b0;
    len        = 1 << r.run_order;
    if (r.run_order > MAX_RUN_ORDER || len > PAGES_PER_CHUNK) begin
      // Oversized run: rejected for both opcodes, nothing changes.
      res.status = ST_RANGE;
    end else if (r.opcode == OP_ALLOC) begin
      // First fit: chunks in order, window slides one page at a time.
      for (int c = 0; c < CHUNK_COUNT && !found; c++) begin
        for (int p = 0; p + len <= PAGES_PER_CHUNK && !found; p++) begin
          win = span_mask(len, p);
          if ((free_map[c] & win) == win) begin
            free_map[c]       &= ~win;
            mirror_count      -= COUNT_W'(len);
            res.granted_chunk  = CHUNK_W'(c);
            res.granted_page   = PAGE_W'(p);
            found              = 1'b1;
            live_runs.push_back('{CHUNK_W'(c), PAGE_W'(p), r.run_order});
          end
        end
      end
      if (!found) res.status = ST_NO_RUN;
    end else if (r.chunk_index >= CHUNK_COUNT || int'(r.page_index) + len > PAGES_PER_CHUNK) begin
      res.status = ST_RANGE;
    end else begin
      win = span_mask(len, int'(r.page_index));
      // Any page of the run already free makes it a double free, even partly.
      if ((free_map[r.chunk_index] & win) != '0) begin
        res.status = ST_DOUBLE_FREE;
      end else begin
        free_map[r.chunk_index] |= win;
        mirror_count            += COUNT_W'(len);
      end
    end
    res.pages_available = mirror_count;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(input op_t op, input int order, input int chunk,
                                    input int page);
    req_t r;
    r.opcode      = op;
    r.run_order   = ORDER_W'(order);
    r.chunk_index = CHUNK_W'(chunk);
    r.page_index  = PAGE_W'(page);
    return r;
  endfunction

  // Drive one request beat and hold it until accepted. Bursts of random length
  // are separated by random gaps; valid only drops at the start of a gap, so it
  // never gets two updates in one step.
  task automatic send_request(input req_t item);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    burst_left--;
    expected_rsps.push_back(apply_request(item));
  endtask

  // ---------------------------------------------------------------------------
  // Response side: stall pattern and checker
  // ---------------------------------------------------------------------------

  // Switch between backpressure modes, holding each one for a random stretch.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(10, 150);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:  rsp_stall <= 1'b0;
        RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
        RX_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
        default:  rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every accepted response beat with the oldest prediction.
  always @(posedge clk) begin : check_responses
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("response beat with nothing expected: %p", rsp);
        mismatches++;
      end else begin
        want = expected_rsps.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("granted_chunk", want.granted_chunk, rsp.granted_chunk);
        check_field("granted_page", want.granted_page, rsp.granted_page);
        check_field("pages_available", want.pages_available, rsp.pages_available);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh maps: single page, an unaligned pair, then a whole chunk.
  // Free-only fields are set to all ones on one beat; allocate must ignore them.
  task automatic test_first_fit();
    send_request(make_req(OP_ALLOC, 0, 7, 15));
    send_request(make_req(OP_ALLOC, 1, 0, 0));
    send_request(make_req(OP_ALLOC, 4, 5, 9));
  endtask

  // Oversized orders on both opcodes, a chunk past the end, a run past the chunk end.
  task automatic test_range_checks();
    send_request(make_req(OP_ALLOC, 5, 0, 0));
    send_request(make_req(OP_ALLOC, 6, 0, 0));
    send_request(make_req(OP_FREE, 7, 3, 0));
    send_request(make_req(OP_FREE, 0, 7, 0));
    send_request(make_req(OP_FREE, 1, 6, 15));
  endtask

  // Partly free run, a page freed twice, frees that return every page, a never-taken page.
  task automatic test_double_free();
    send_request(make_req(OP_FREE, 1, 0, 2));
    send_request(make_req(OP_FREE, 0, 0, 0));
    send_request(make_req(OP_FREE, 0, 0, 0));
    send_request(make_req(OP_FREE, 4, 1, 0));
    send_request(make_req(OP_FREE, 1, 0, 1));
    send_request(make_req(OP_FREE, 0, 6, 15));
  endtask

  // Take every chunk whole, then ask for more with no room left.
  task automatic test_exhaustion();
    for (int c = 0; c < CHUNK_COUNT; c++) send_request(make_req(OP_ALLOC, 4, 0, 0));
    send_request(make_req(OP_ALLOC, 0, 0, 0));
    send_request(make_req(OP_ALLOC, 4, 0, 0));
  endtask

  // Mostly well-formed traffic: allocates of mostly small runs and frees of
  // runs that were granted, with some fully random beats mixed in. The mix
  // swings between filling and draining so both extremes of occupancy recur.
  task automatic test_random_traffic();
    req_t item;
    run_t victim;
    int   alloc_pct;
    int   pick;
    int   roll;
    int   idx;
    alloc_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) begin
        case ($urandom_range(0, 2))
          0:       alloc_pct = 85;
          1:       alloc_pct = 55;
          default: alloc_pct = 20;
        endcase
      end
      item = make_req(op_t'($urandom_range(0, 1)), $urandom_range(0, 7),
                      $urandom_range(0, 7), $urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // Keep the beat fully random: range errors, stray frees, double frees.
      end else if (live_runs.size() == 0 || $urandom_range(0, 99) < alloc_pct) begin
        roll           = $urandom_range(0, 15);
        item.opcode    = OP_ALLOC;
        item.run_order = (roll < 6) ? 0 : (roll < 10) ? 1 : (roll < 13) ? 2 : (roll < 15) ? 3 : 4;
      end else begin
        idx               = $urandom_range(0, live_runs.size() - 1);
        victim            = live_runs[idx];
        live_runs.delete(idx);
        item.opcode       = OP_FREE;
        item.run_order    = victim.order;
        item.chunk_index  = victim.chunk;
        item.page_index   = victim.page;
      end
      send_request(item);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_mirror();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_first_fit();
    test_range_checks();
    test_double_free();
    test_exhaustion();
    test_random_traffic();
    req_valid <= 1'b0;

    // Drain outstanding responses, then watch a little longer for strays.
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pba_pkg.sv
src/pba_cell.sv
src/page_bitmap_allocator.sv
sim/tb_page_bitmap_allocator.sv
